/* src/lrfd_pkg.sv */
// ----------------------------------------------------------------------------
// lrfd_pkg
// Shared constants for the laser range frame decoder and its channels.
// ----------------------------------------------------------------------------
`default_nettype none

package lrfd_pkg;

    localparam int unsigned DIST_W     = 26;
    localparam int unsigned KIND_W     = 2;
    localparam int unsigned SILENCE_W  = 17;
    localparam int unsigned TIMEOUT_W  = 16;
    localparam int unsigned COUNT_W    = 4;
    localparam int unsigned APB_ADDR_W = 3;
    localparam int unsigned APB_DATA_W = 32;

    localparam logic [7:0] SYNC_BYTE   = 8'h80;
    localparam logic [7:0] ID_BYTE     = 8'h06;
    localparam logic [7:0] ASCII_E     = 8'h45;
    localparam logic [7:0] ASCII_R     = 8'h52;
    localparam logic [7:0] ASCII_ZERO  = 8'h30;

    // bytes 0..9 are held, byte 10 carries the checksum
    localparam logic [COUNT_W-1:0] LAST_IDX = 4'd10;

    localparam logic [COUNT_W-1:0] IDX_ID     = 4'd1;
    localparam logic [COUNT_W-1:0] IDX_D5     = 4'd3;
    localparam logic [COUNT_W-1:0] IDX_D4     = 4'd4;
    localparam logic [COUNT_W-1:0] IDX_D3     = 4'd5;
    localparam logic [COUNT_W-1:0] IDX_D2     = 4'd7;
    localparam logic [COUNT_W-1:0] IDX_D1     = 4'd8;
    localparam logic [COUNT_W-1:0] IDX_D0     = 4'd9;

    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd500;
    localparam logic [SILENCE_W-1:0] SILENCE_MAX   = 17'h1FFFF;

    localparam logic [APB_ADDR_W-1:0] ADDR_TIMEOUT = 3'd0;

    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    localparam logic [KIND_W-1:0] KIND_DISTANCE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ERROR    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RESTART  = 2'd2;

    function automatic logic [16:0] digit_weight(input logic [COUNT_W-1:0] idx);
        logic [16:0] w;
        unique case (idx)
            IDX_D5:  w = 17'd100000;
            IDX_D4:  w = 17'd10000;
            IDX_D3:  w = 17'd1000;
            IDX_D2:  w = 17'd100;
            IDX_D1:  w = 17'd10;
            IDX_D0:  w = 17'd1;
            default: w = 17'd0;
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

/* src/lrfd_if.sv */
// ----------------------------------------------------------------------------
// lrfd channel interfaces
// Valid/ready channels for received bytes and ticks, and for decoded results.
// ----------------------------------------------------------------------------
`default_nettype none

interface lrfd_in_if
    import lrfd_pkg::*;
();
    logic       valid;
    logic       ready;
    logic       command;
    logic [7:0] rx_byte;

    modport source (output valid, output command, output rx_byte, input ready);
    modport sink   (input valid, input command, input rx_byte, output ready);
endinterface

interface lrfd_out_if
    import lrfd_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [KIND_W-1:0]        result_kind;
    logic signed [DIST_W-1:0] distance_thousandths;

    modport source (output valid, output result_kind, output distance_thousandths,
                    input ready);
    modport sink   (input valid, input result_kind, input distance_thousandths,
                    output ready);
endinterface

`default_nettype wire

/* src/laser_range_frame_decoder.sv */
// A result is presented in the cycle after the beat that causes it.
// Throughput: one beat per cycle; the input stalls only while a held result
//   is not taken (single output register).
// Distance digits are weighted and summed one byte at a time as they arrive.
// Reset (i_rst_n low, synchronous): idle awaiting sync, silence count zero,
//   timeout 500, output empty.
// ----------------------------------------------------------------------------
// laser_range_frame_decoder
// Parses 11-byte rangefinder frames, checks header and checksum, reports
// distance or sensor error, and requests a restart after prolonged silence.
// ----------------------------------------------------------------------------
`default_nettype none

module laser_range_frame_decoder
    import lrfd_pkg::*;
(
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    lrfd_in_if.sink                i_in,
    lrfd_out_if.source             o_res,
    input  wire                    psel,
    input  wire                    penable,
    input  wire                    pwrite,
    input  wire [APB_ADDR_W-1:0]   paddr,
    input  wire [APB_DATA_W-1:0]   pwdata,
    output logic [APB_DATA_W-1:0]  prdata,
    output logic                   pready
);

    logic [TIMEOUT_W-1:0]     r_timeout;
    logic [COUNT_W-1:0]       r_count,   n_count;
    logic [7:0]               r_sum,     n_sum;
    logic                     r_hdr_ok,  n_hdr_ok;
    logic                     r_err_ok,  n_err_ok;
    logic [DIST_W-1:0]        r_acc,     n_acc;
    logic [SILENCE_W-1:0]     r_silence, n_silence;
    logic                     r_out_valid, n_out_valid;
    logic [KIND_W-1:0]        r_kind,    n_kind;
    logic [DIST_W-1:0]        r_dist,    n_dist;

    logic                     in_fire;
    logic                     cfg_wr;
    logic [SILENCE_W-1:0]     silence_inc;
    logic [DIST_W-1:0]        digit_ext;
    logic [DIST_W-1:0]        term;
    logic [8:0]               digit;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && (paddr == ADDR_TIMEOUT);
    assign prdata  = (paddr == ADDR_TIMEOUT) ? {{(APB_DATA_W-TIMEOUT_W){1'b0}}, r_timeout}
                                             : '0;

    assign i_in.ready = !r_out_valid || o_res.ready;
    assign in_fire    = i_in.valid && i_in.ready;

    assign o_res.valid                = r_out_valid;
    assign o_res.result_kind          = r_kind;
    assign o_res.distance_thousandths = $signed(r_dist);

    assign silence_inc = (r_silence < SILENCE_MAX) ? r_silence + 1'b1 : r_silence;
    assign digit       = {1'b0, i_in.rx_byte} - {1'b0, ASCII_ZERO};
    assign digit_ext   = {{(DIST_W-9){digit[8]}}, digit};
    assign term        = DIST_W'(digit_ext * {{(DIST_W-17){1'b0}}, digit_weight(r_count)});

    always_comb begin
        n_count     = r_count;
        n_sum       = r_sum;
        n_hdr_ok    = r_hdr_ok;
        n_err_ok    = r_err_ok;
        n_acc       = r_acc;
        n_silence   = r_silence;
        n_out_valid = r_out_valid && !o_res.ready;
        n_kind      = r_kind;
        n_dist      = r_dist;

        if (in_fire) begin
            if (i_in.command == CMD_TICK) begin
                n_silence = silence_inc;
                if (silence_inc > {1'b0, r_timeout}) begin
                    n_silence   = '0;
                    n_out_valid = 1'b1;
                    n_kind      = KIND_RESTART;
                    n_dist      = '0;
                end
            end else if (r_count == '0) begin
                if (i_in.rx_byte == SYNC_BYTE) begin
                    n_count  = 4'd1;
                    n_sum    = i_in.rx_byte;
                    n_acc    = '0;
                    n_hdr_ok = 1'b0;
                    n_err_ok = 1'b0;
                end
            end else if (r_count != LAST_IDX) begin
                n_count = r_count + 1'b1;
                n_sum   = r_sum + i_in.rx_byte;
                n_acc   = r_acc + term;
                if (r_count == IDX_ID) begin
                    n_hdr_ok = (i_in.rx_byte == ID_BYTE);
                end
                if (r_count == IDX_D5) begin
                    n_err_ok = (i_in.rx_byte == ASCII_E);
                end
                if (r_count == IDX_D4 || r_count == IDX_D3) begin
                    n_err_ok = r_err_ok && (i_in.rx_byte == ASCII_R);
                end
            end else begin
                n_count = '0;
                if (r_hdr_ok && (8'(r_sum + i_in.rx_byte) == 8'd0)) begin
                    n_silence   = '0;
                    n_out_valid = 1'b1;
                    if (r_err_ok) begin
                        n_kind = KIND_ERROR;
                        n_dist = '0;
                    end else begin
                        n_kind = KIND_DISTANCE;
                        n_dist = r_acc;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout   <= TIMEOUT_RESET;
            r_count     <= '0;
            r_sum       <= '0;
            r_silence   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (cfg_wr) begin
                r_timeout <= pwdata[TIMEOUT_W-1:0];
            end
            r_count     <= n_count;
            r_sum       <= n_sum;
            r_silence   <= n_silence;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hdr_ok <= n_hdr_ok;
        r_err_ok <= n_err_ok;
        r_acc    <= n_acc;
        r_kind   <= n_kind;
        r_dist   <= n_dist;
    end

`ifndef NO_ASSERTIONS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= LAST_IDX)
        else $error("frame byte count out of range");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> i_in.ready)
        else $error("input stalled with empty output register");

    a_tick_keeps_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && i_in.command == CMD_TICK) |=> r_count == $past(r_count))
        else $error("tick disturbed frame position");

    a_restart_zero_dist: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_kind != KIND_DISTANCE) |-> r_dist == '0)
        else $error("non-distance result carries a distance");

    a_restart_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && i_in.command == CMD_TICK && n_kind == KIND_RESTART && n_out_valid
         && !(r_out_valid && !o_res.ready)) |=> r_silence == '0)
        else $error("silence count not cleared on restart request");
`endif

endmodule

`default_nettype wire
